// ===== hdl/cau_pkg.sv =====
// ---------------------------------------------------------------------------
// cau_pkg: shared types for the complex arithmetic unit
// Operation codes and the packed operand and result transaction structs.
// ---------------------------------------------------------------------------
package cau_pkg;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] a_real;
        logic signed [31:0] a_imag;
        logic signed [31:0] b_real;
        logic signed [31:0] b_imag;
    } operands_t;

    typedef struct packed {
        logic signed [31:0] result_real;
        logic signed [31:0] result_imag;
        logic               overflow;
        logic               div_by_zero;
    } result_t;

endpackage

// ===== hdl/cau_div_pipe.sv =====
// ---------------------------------------------------------------------------
// cau_div_pipe: pipelined restoring divider for one result part
// Computes floor(mag * 2^FRAC_BITS / den) one quotient bit per stage, with an
// early flag for quotients too large to represent. Non-divide items pass the
// magnitude through unchanged.
// ---------------------------------------------------------------------------
module cau_div_pipe #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_divide,
    input  logic                      in_neg,
    input  logic [2*DATA_WIDTH:0]     in_mag,
    input  logic [2*DATA_WIDTH-1:0]   in_den,
    output logic                      out_valid,
    output logic                      out_neg,
    output logic                      out_big,
    output logic [2*DATA_WIDTH:0]     out_mag
);

    localparam int MW   = 2 * DATA_WIDTH + 1;
    localparam int DENW = 2 * DATA_WIDTH;
    localparam int QB   = DATA_WIDTH + 1;
    localparam int NW   = MW + FRAC_BITS;
    localparam int CW   = NW + QB;

    typedef struct packed {
        logic            divide;
        logic            neg;
        logic            big;
        logic [NW-1:0]   rem;
        logic [DENW-1:0] den;
        logic [MW-1:0]   q;
    } stage_t;

    stage_t       pipe_reg [0:QB];
    stage_t       pipe_next [0:QB];
    logic [QB:0]  valid_reg;

    // The first stage only checks whether the quotient reaches 2^QB.
    always_comb
    begin
        pipe_next[0].divide = in_divide;
        pipe_next[0].neg    = in_neg;
        pipe_next[0].rem    = NW'(in_mag) << FRAC_BITS;
        pipe_next[0].den    = in_den;
        pipe_next[0].q      = in_divide ? '0 : in_mag;
        pipe_next[0].big    = in_divide &&
            (CW'(pipe_next[0].rem) >= (CW'(in_den) << QB));
    end

    for (genvar s = 1; s <= QB; s++)
    begin : g_stage
        logic [CW-1:0] shifted;
        always_comb
        begin
            pipe_next[s] = pipe_reg[s-1];
            shifted      = CW'(pipe_reg[s-1].den) << (QB - s);
            if (pipe_reg[s-1].divide && !pipe_reg[s-1].big &&
                CW'(pipe_reg[s-1].rem) >= shifted)
            begin
                pipe_next[s].rem      = NW'(CW'(pipe_reg[s-1].rem) - shifted);
                pipe_next[s].q[QB-s]  = 1'b1;
            end
        end
    end

    for (genvar s = 0; s <= QB; s++)
    begin : g_reg
        always_ff @(posedge clk)
        begin
            pipe_reg[s] <= pipe_next[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[QB-1:0], in_valid};
        end
    end

    assign out_valid = valid_reg[QB];
    assign out_neg   = pipe_reg[QB].neg;
    assign out_big   = pipe_reg[QB].big;
    assign out_mag   = pipe_reg[QB].q;

endmodule

// ===== hdl/complex_arith_unit.sv =====
// ---------------------------------------------------------------------------
// complex_arith_unit: pipelined complex add, subtract, multiply and divide
// Signed fixed-point complex ALU with saturation and divide-by-zero flag.
// ---------------------------------------------------------------------------
// Usage: drive the operands struct and pulse start; a transaction is taken
// at every rising edge where start is high and busy is low. Busy is always
// low, so a new transaction may be issued in every cycle.
// Every transaction yields exactly one result, which sits on the result port
// for one cycle while done is high. Results leave in issue order.
// Every operation takes the same path: one stage of multipliers, one
// stage of sums, one stage that detects oversized quotients, one
// restoring-division stage per quotient bit (DATA_WIDTH + 1 of them) and
// the output register. Add, subtract and multiply items ride through the
// division stages untouched. Throughput is one transaction per cycle.
// Reset clears only the valid bits; no result appears until fed again.
// The receiver cannot stall, so the pipeline never holds.
// Multiply rounds toward minus infinity, divide truncates toward zero, and
// each part saturates to the DATA_WIDTH signed range.
// ---------------------------------------------------------------------------
module complex_arith_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  cau_pkg::operands_t operands,
    output logic               done,
    output cau_pkg::result_t   result
);

    import cau_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int MW   = 2 * DW + 1;
    localparam int DENW = 2 * DW;
    localparam int QB   = DW + 1;
    localparam logic [MW-1:0] POS_LIM = MW'((64'd1 << (DW - 1)) - 64'd1);
    localparam logic [MW-1:0] NEG_LIM = MW'(64'd1 << (DW - 1));

    // Stage one: products and the plain sums.
    logic signed [DW-1:0]   ar, ai, br, bi;
    logic                   s1_valid_reg;
    logic [1:0]             s1_kind_reg;
    logic signed [DW:0]     s1_re_reg, s1_im_reg;
    logic signed [DENW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [DENW-1:0] p_bb_reg, p_cc_reg;

    assign ar = operands.a_real[DW-1:0];
    assign ai = operands.a_imag[DW-1:0];
    assign br = operands.b_real[DW-1:0];
    assign bi = operands.b_imag[DW-1:0];

    always_ff @(posedge clk)
    begin
        s1_kind_reg <= operands.kind;
        if (operands.kind == KIND_SUB)
        begin
            s1_re_reg <= (DW+1)'(ar) - (DW+1)'(br);
            s1_im_reg <= (DW+1)'(ai) - (DW+1)'(bi);
        end
        else
        begin
            s1_re_reg <= (DW+1)'(ar) + (DW+1)'(br);
            s1_im_reg <= (DW+1)'(ai) + (DW+1)'(bi);
        end
        p_rr_reg <= DENW'(ar) * DENW'(br);
        p_ii_reg <= DENW'(ai) * DENW'(bi);
        p_ri_reg <= DENW'(ar) * DENW'(bi);
        p_ir_reg <= DENW'(ai) * DENW'(br);
        p_bb_reg <= DENW'(br) * DENW'(br);
        p_cc_reg <= DENW'(bi) * DENW'(bi);
    end

    // Stage two: sums of products, the squared magnitude and sign/magnitude
    // form for the division stages.
    logic signed [MW-1:0]   re_val, im_val;
    logic [DENW-1:0]        den_next;
    logic                   dz_next, divide_next;
    logic                   s2_valid_reg, s2_divide_reg, s2_dz_reg;
    logic                   s2_re_neg_reg, s2_im_neg_reg;
    logic [MW-1:0]          s2_re_mag_reg, s2_im_mag_reg;
    logic [DENW-1:0]        s2_den_reg;

    always_comb
    begin
        den_next    = DENW'(p_bb_reg) + DENW'(p_cc_reg);
        dz_next     = (s1_kind_reg == KIND_DIV) && (den_next == '0);
        divide_next = (s1_kind_reg == KIND_DIV) && !dz_next;
        unique case (s1_kind_reg)
            KIND_ADD, KIND_SUB:
            begin
                re_val = MW'(s1_re_reg);
                im_val = MW'(s1_im_reg);
            end
            KIND_MUL:
            begin
                re_val = (MW'(p_rr_reg) - MW'(p_ii_reg)) >>> FRAC_BITS;
                im_val = (MW'(p_ri_reg) + MW'(p_ir_reg)) >>> FRAC_BITS;
            end
            default:
            begin
                if (dz_next)
                begin
                    re_val = '0;
                    im_val = '0;
                end
                else
                begin
                    re_val = MW'(p_rr_reg) + MW'(p_ii_reg);
                    im_val = MW'(p_ir_reg) - MW'(p_ri_reg);
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s2_divide_reg <= divide_next;
        s2_dz_reg     <= dz_next;
        s2_den_reg    <= den_next;
        s2_re_neg_reg <= re_val[MW-1];
        s2_im_neg_reg <= im_val[MW-1];
        s2_re_mag_reg <= re_val[MW-1] ? MW'(-re_val) : MW'(re_val);
        s2_im_mag_reg <= im_val[MW-1] ? MW'(-im_val) : MW'(im_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Division stages, one per result part.
    logic          re_valid, im_valid, re_neg, im_neg, re_big, im_big;
    logic [MW-1:0] re_mag, im_mag;
    logic [QB:0]   dz_pipe_reg;

    cau_div_pipe #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_re (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_divide (s2_divide_reg),
        .in_neg    (s2_re_neg_reg),
        .in_mag    (s2_re_mag_reg),
        .in_den    (s2_den_reg),
        .out_valid (re_valid),
        .out_neg   (re_neg),
        .out_big   (re_big),
        .out_mag   (re_mag)
    );

    cau_div_pipe #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div_im (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_divide (s2_divide_reg),
        .in_neg    (s2_im_neg_reg),
        .in_mag    (s2_im_mag_reg),
        .in_den    (s2_den_reg),
        .out_valid (im_valid),
        .out_neg   (im_neg),
        .out_big   (im_big),
        .out_mag   (im_mag)
    );

    // The zero-divisor flag travels alongside the division stages.
    always_ff @(posedge clk)
    begin
        dz_pipe_reg <= {dz_pipe_reg[QB-1:0], s2_dz_reg};
    end

    // Output stage: saturation to the DATA_WIDTH range.
    logic                 re_sat, im_sat;
    logic signed [DW-1:0] re_out, im_out;
    logic                 done_reg;
    result_t              result_reg;

    always_comb
    begin
        re_sat = re_big || (re_neg ? (re_mag > NEG_LIM) : (re_mag > POS_LIM));
        im_sat = im_big || (im_neg ? (im_mag > NEG_LIM) : (im_mag > POS_LIM));
        if (re_sat)
        begin
            re_out = re_neg ? DW'(NEG_LIM) : DW'(POS_LIM);
        end
        else
        begin
            re_out = re_neg ? DW'(-re_mag) : DW'(re_mag);
        end
        if (im_sat)
        begin
            im_out = im_neg ? DW'(NEG_LIM) : DW'(POS_LIM);
        end
        else
        begin
            im_out = im_neg ? DW'(-im_mag) : DW'(im_mag);
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.result_real <= 32'(re_out);
        result_reg.result_imag <= 32'(im_out);
        result_reg.overflow    <= re_sat || im_sat;
        result_reg.div_by_zero <= dz_pipe_reg[QB];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= re_valid && im_valid;
        end
    end

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

endmodule
